FILE: hdl/humidity_temp_frame_decode_defines.svh
// ----------------------------------------------------------------------------
// humidity_temp_frame_decode_defines.svh
// Assertion macros used by the frame decoder top module.
// ----------------------------------------------------------------------------
`ifndef HUMIDITY_TEMP_FRAME_DECODE_DEFINES_SVH
`define HUMIDITY_TEMP_FRAME_DECODE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define HTFD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("htfd same-cycle check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define HTFD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("htfd next-cycle check failed");

`endif

FILE: hdl/htfd_pkg.sv
// ----------------------------------------------------------------------------
// htfd_pkg
// Constants, types and the CRC-8 step shared by the frame decoder.
// ----------------------------------------------------------------------------
package htfd_pkg;

  localparam logic [7:0]         CRC_POLY    = 8'h31;
  localparam logic [15:0]        STATUS_MASK = 16'h0003;

  localparam logic               KIND_TEMP   = 1'b0;
  localparam logic               KIND_RH     = 1'b1;

  localparam logic [14:0]        T_SCALE     = 15'd17572;
  localparam logic [14:0]        RH_SCALE    = 15'd12500;
  localparam logic signed [15:0] T_OFFSET    = -16'sd4685;
  localparam logic signed [15:0] RH_OFFSET   = -16'sd600;

  typedef struct packed {
    logic        crc_error;
    logic [15:0] masked_raw;
  } check_t;

  // One data byte through the CRC-8, msb first.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: hdl/htfd_in_if.sv
// ----------------------------------------------------------------------------
// htfd_in_if
// Input channel: one sensor reply word and its measurement kind.
// ----------------------------------------------------------------------------
interface htfd_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] raw_high;
  logic [7:0] raw_low;
  logic [7:0] check_byte;

  modport source (output valid, kind, raw_high, raw_low, check_byte, input ready);
  modport sink   (input valid, kind, raw_high, raw_low, check_byte, output ready);
endinterface

FILE: hdl/htfd_out_if.sv
// ----------------------------------------------------------------------------
// htfd_out_if
// Result channel: converted reading, check status and masked raw word.
// ----------------------------------------------------------------------------
interface htfd_out_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] value;
  logic               crc_error;
  logic [15:0]        masked_raw;

  modport source (output valid, value, crc_error, masked_raw, input ready);
  modport sink   (input valid, value, crc_error, masked_raw, output ready);
endinterface

FILE: hdl/htfd_check.sv
// ----------------------------------------------------------------------------
// htfd_check
// CRC-8 over the two data bytes, compare, and status-bit masking.
// ----------------------------------------------------------------------------
module htfd_check (
  input  logic             [7:0] raw_high,
  input  logic             [7:0] raw_low,
  input  logic             [7:0] check_byte,
  output htfd_pkg::check_t       chk
);

  logic [7:0] crc_hi;
  logic [7:0] crc_all;
  logic       mismatch;

  assign crc_hi   = htfd_pkg::crc8_byte(8'h00, raw_high);
  assign crc_all  = htfd_pkg::crc8_byte(crc_hi, raw_low);
  assign mismatch = (crc_all != check_byte);

  // drop the status bits; a bad frame converts as raw zero
  assign chk.crc_error  = mismatch;
  assign chk.masked_raw = mismatch ? 16'h0000
                                   : ({raw_high, raw_low} & ~htfd_pkg::STATUS_MASK);

endmodule

FILE: hdl/htfd_conv.sv
// ----------------------------------------------------------------------------
// htfd_conv
// Scale the masked raw word to hundredths of degC or of percent RH.
// ----------------------------------------------------------------------------
module htfd_conv (
  input  logic               kind,
  input  logic        [15:0] raw,
  output logic signed [14:0] value
);

  logic        [14:0] scale;
  logic signed [15:0] offset;
  logic        [30:0] prod;
  logic signed [15:0] sum;

  assign scale  = (kind == htfd_pkg::KIND_RH) ? htfd_pkg::RH_SCALE  : htfd_pkg::T_SCALE;
  assign offset = (kind == htfd_pkg::KIND_RH) ? htfd_pkg::RH_OFFSET : htfd_pkg::T_OFFSET;

  // product stays below 2^31; floor by 2^16 is the upper slice
  assign prod  = 31'(scale) * 31'(raw);
  assign sum   = offset + $signed({1'b0, prod[30:16]});
  assign value = sum[14:0];

endmodule

FILE: hdl/humidity_temp_frame_decode.sv
// ----------------------------------------------------------------------------
// humidity_temp_frame_decode
// Sensor reply decoder: CRC-8 check, status masking and unit conversion.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one three-byte reply (raw_high, raw_low, check_byte) and
//   the measurement kind; out_chan returns one word per reply: the reading
//   in hundredths of degC or percent RH, the crc_error flag and the masked
//   raw word. A set crc_error asks the host to soft-reset the sensor; such a
//   word carries masked_raw zero and the conversion of zero.
//   Both channels use valid/ready; a word moves when both are high.
//   An accepted word is held in the input register and then in the result
//   register, which drives out_chan. One input register, then the CRC,
//   mask and a single 15x16 multiply-add feed the result register.
//   Throughput is one word per cycle while out_chan.ready stays high, set
//   by that one register-to-register path.
//   A stalled receiver holds the result register; the input register still
//   takes one more word, after which in_chan.ready drops until out_chan.ready
//   returns. Synchronous reset (rst_n low) empties both registers; there is
//   no other state.
// ----------------------------------------------------------------------------
`include "humidity_temp_frame_decode_defines.svh"

module humidity_temp_frame_decode (
  input  logic clk,
  input  logic rst_n,
  htfd_in_if.sink    in_chan,
  htfd_out_if.source out_chan
);

  logic                s1_valid_r;
  logic                s1_kind_r;
  logic         [7:0]  s1_high_r;
  logic         [7:0]  s1_low_r;
  logic         [7:0]  s1_check_r;

  logic                out_valid_r;
  logic signed  [14:0] out_value_r;
  logic                out_error_r;
  logic         [15:0] out_raw_r;

  logic                out_free;
  logic                s1_move;
  logic                in_take;
  htfd_pkg::check_t    chk;
  logic signed  [14:0] conv_value;

  assign out_free      = !out_valid_r || out_chan.ready;
  assign s1_move       = s1_valid_r && out_free;
  assign in_chan.ready = !s1_valid_r || out_free;
  assign in_take       = in_chan.valid && in_chan.ready;

  htfd_check u_check (
    .raw_high   (s1_high_r),
    .raw_low    (s1_low_r),
    .check_byte (s1_check_r),
    .chk        (chk)
  );

  htfd_conv u_conv (
    .kind  (s1_kind_r),
    .raw   (chk.masked_raw),
    .value (conv_value)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
    if (in_take) begin
      s1_kind_r  <= in_chan.kind;
      s1_high_r  <= in_chan.raw_high;
      s1_low_r   <= in_chan.raw_low;
      s1_check_r <= in_chan.check_byte;
    end
  end

  // result register: advance when empty or taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
    if (s1_move) begin
      out_value_r <= conv_value;
      out_error_r <= chk.crc_error;
      out_raw_r   <= chk.masked_raw;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.value      = out_value_r;
  assign out_chan.crc_error  = out_error_r;
  assign out_chan.masked_raw = out_raw_r;

  `HTFD_ASSERT_SAME(a_err_zero_raw, out_valid_r && out_error_r, out_raw_r == 16'h0000)
  `HTFD_ASSERT_SAME(a_err_value,
                    out_valid_r && out_error_r,
                    (out_value_r == 15'(htfd_pkg::T_OFFSET)) ||
                    (out_value_r == 15'(htfd_pkg::RH_OFFSET)))
  `HTFD_ASSERT_SAME(a_status_clear, out_valid_r, out_raw_r[1:0] == 2'b00)
  `HTFD_ASSERT_NEXT(a_fill_empty, s1_valid_r && !out_valid_r, out_valid_r)

endmodule
